// ===== rtl/core/tahsg_pkg.sv =====
// Package: shared types, constants and codes for the homing step generator.
`timescale 1ns / 1ps
package tahsg_pkg;
  localparam int NumAxes   = 3;
  localparam int CountBits = 20;
  localparam int RateBits  = 19;
  localparam logic [CountBits-1:0] TimerHz = 20'd1000000;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  localparam logic [1:0] ModeIdle = 2'd0;
  localparam logic [1:0] ModeBusy = 2'd1;
  localparam logic [1:0] ModeHome = 2'd2;

  localparam logic [2:0] PhCheck   = 3'd0;
  localparam logic [2:0] PhBackoff = 3'd1;
  localparam logic [2:0] PhFast    = 3'd2;
  localparam logic [2:0] PhSlow    = 3'd3;
  localparam logic [2:0] PhDone    = 3'd4;

  localparam logic [1:0] RegFast    = 2'd0;
  localparam logic [1:0] RegSlow    = 2'd1;
  localparam logic [1:0] RegMax     = 2'd2;
  localparam logic [1:0] RegBackoff = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic div_go;     // launch one division
    logic [1:0] div_sel; // 0 fast, 1 slow
    logic tick;       // commit the tick update
    logic start_cmd;  // commit a start request
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;
endpackage

// ===== rtl/core/tahsg_if.sv =====
// Interface: valid/ready channel with generic payload.
`timescale 1ns / 1ps
interface tahsg_if #(parameter int W = 4);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/tahsg_div.sv =====
// Module: iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tahsg_div (
  input  logic clk,
  input  logic rst_n,
  input  logic go,
  input  logic [tahsg_pkg::RateBits-1:0] den,
  output logic done,
  output logic [tahsg_pkg::CountBits-1:0] quo
);
  import tahsg_pkg::*;
  logic [CountBits-1:0] q_r, q_nxt;
  logic [RateBits:0] rem_r, rem_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [RateBits:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    trial = {rem_r[RateBits-1:0], q_r[CountBits-1]};
    if (go) begin
      q_nxt = TimerHz; rem_nxt = '0; cnt_nxt = 5'(CountBits); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        q_nxt = {q_r[CountBits-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[CountBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_nxt = 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
  end
  assign done = busy_r && (cnt_r == 5'd1);
  assign quo = q_nxt;
endmodule

// ===== rtl/core/tahsg_dp.sv =====
// Module: datapath with config registers, per-axis state and period divider.
`timescale 1ns / 1ps
module tahsg_dp (
  input  logic clk,
  input  logic rst_n,
  input  tahsg_pkg::dp_cmd_t cmd,
  output tahsg_pkg::dp_sts_t sts,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [31:0] cfg_wdata,
  output logic [31:0] cfg_rdata,
  input  logic [2:0] sensors,
  output logic [18:0] result
);
  import tahsg_pkg::*;
  logic [RateBits-1:0] fast_r, slow_r, max_r;
  logic [CountBits-1:0] boff_r;
  logic [CountBits-1:0] pfast_r, pslow_r;
  logic [1:0] mode_r [NumAxes];
  logic [2:0] ph_r [NumAxes];
  logic act_r;
  logic [CountBits-1:0] pm1_r [NumAxes];
  logic [CountBits-1:0] pc_r [NumAxes];
  logic [CountBits-1:0] sl_r [NumAxes];
  logic unl_r [NumAxes];
  logic dir_r [NumAxes];
  logic trg_r [NumAxes];
  logic sp_r [NumAxes];
  logic [2:0] out_step_r, out_run_r;

  logic [RateBits-1:0] rate, den;
  logic div_done;
  logic [CountBits-1:0] quo, per;

  always_comb begin
    rate = (cmd.div_sel == 2'd0) ? fast_r : slow_r;
    den = (rate > max_r) ? max_r : rate;
    if (den == '0) den = RateBits'(1);
  end
  tahsg_div u_div (.clk, .rst_n, .go(cmd.div_go), .den, .done(div_done), .quo);
  assign sts.div_done = div_done;
  always_comb begin
    per = quo - CountBits'(1);
    if (quo < CountBits'(3)) per = CountBits'(2);
  end

  always_comb begin
    case (cfg_idx)
      RegFast: cfg_rdata = 32'(fast_r);
      RegSlow: cfg_rdata = 32'(slow_r);
      RegMax:  cfg_rdata = 32'(max_r);
      default: cfg_rdata = 32'(boff_r);
    endcase
  end

  // next-state variables for the whole tick
  logic [1:0] m [NumAxes];
  logic [2:0] p [NumAxes];
  logic [CountBits-1:0] pm [NumAxes], pc [NumAxes], sl [NumAxes];
  logic u [NumAxes], d [NumAxes], t [NumAxes], s [NumAxes];
  logic act, every;
  logic [2:0] stp, run;
  logic lvl;
  logic [CountBits-1:0] half;

  always_comb begin
    act = act_r; stp = '0; run = '0; every = 1'b1; lvl = 1'b1; half = '0;
    for (int a = 0; a < NumAxes; a++) begin
      m[a] = mode_r[a]; p[a] = ph_r[a]; pm[a] = pm1_r[a]; pc[a] = pc_r[a];
      sl[a] = sl_r[a]; u[a] = unl_r[a]; d[a] = dir_r[a]; t[a] = trg_r[a];
      s[a] = sp_r[a];
    end
    if (cmd.start_cmd) begin
      act = 1'b1;
      for (int a = 0; a < NumAxes; a++) begin
        m[a] = ModeHome; pc[a] = '0; sl[a] = '0; u[a] = 1'b0;
        p[a] = PhCheck; t[a] = 1'b0; s[a] = sensors[a];
      end
    end else if (cmd.tick) begin
      for (int a = 0; a < NumAxes; a++) begin
        lvl = sensors[a];
        if (s[a] && !lvl) begin
          m[a] = ModeIdle; pc[a] = '0; sl[a] = '0; u[a] = 1'b0; t[a] = 1'b1;
        end
        s[a] = lvl;
      end
      if (act) begin
        for (int a = 0; a < NumAxes; a++) begin
          lvl = sensors[a];
          case (p[a])
            PhCheck: begin
              if (m[a] != ModeBusy) begin
                pm[a] = pfast_r; pc[a] = '0;
                if (!lvl) begin
                  d[a] = 1'b0;
                  if (boff_r == '0) begin
                    m[a] = ModeIdle; sl[a] = '0; u[a] = 1'b0;
                  end else begin
                    u[a] = 1'b0; sl[a] = boff_r; m[a] = ModeBusy;
                  end
                end else begin
                  d[a] = 1'b1; u[a] = 1'b1; sl[a] = '0; m[a] = ModeBusy;
                end
              end
              p[a] = lvl ? PhFast : PhBackoff;
            end
            PhBackoff: begin
              if (m[a] == ModeIdle) begin
                d[a] = 1'b1; pm[a] = pslow_r; pc[a] = '0; u[a] = 1'b1;
                sl[a] = '0; m[a] = ModeBusy; p[a] = PhSlow;
              end
            end
            default: ;
          endcase
          if (t[a]) begin
            t[a] = 1'b0;
            if (p[a] == PhFast) begin
              if (m[a] != ModeBusy) begin
                d[a] = 1'b0; pm[a] = pfast_r; pc[a] = '0;
                if (boff_r == '0) begin
                  m[a] = ModeIdle; sl[a] = '0; u[a] = 1'b0;
                end else begin
                  u[a] = 1'b0; sl[a] = boff_r; m[a] = ModeBusy;
                end
              end
              p[a] = PhBackoff;
            end else if (p[a] == PhSlow) begin
              p[a] = PhDone;
            end
          end
          if (p[a] != PhDone) every = 1'b0;
        end
        if (every) begin
          act = 1'b0;
          for (int a = 0; a < NumAxes; a++) t[a] = 1'b0;
        end
      end
      for (int a = 0; a < NumAxes; a++) begin
        if (m[a] == ModeBusy) begin
          half = CountBits'(({1'b0, pm[a]} + 21'd1) >> 1);
          run[a] = 1'b1;
          stp[a] = pc[a] < half;
          if (pc[a] >= pm[a]) begin
            pc[a] = '0;
            if (!u[a]) begin
              if (sl[a] <= CountBits'(1)) begin
                m[a] = ModeIdle; sl[a] = '0; u[a] = 1'b0;
              end else begin
                sl[a] = sl[a] - CountBits'(1);
              end
            end
          end else begin
            pc[a] = pc[a] + CountBits'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r <= 19'd2000; slow_r <= 19'd500; max_r <= 19'd100000; boff_r <= 20'd1000;
      act_r <= 1'b0; out_step_r <= '0; out_run_r <= '0;
      pfast_r <= 20'd499; pslow_r <= 20'd1999;
      for (int a = 0; a < NumAxes; a++) begin
        mode_r[a] <= ModeIdle; ph_r[a] <= PhCheck; pm1_r[a] <= 20'd2;
        pc_r[a] <= '0; sl_r[a] <= '0; unl_r[a] <= 1'b0; dir_r[a] <= 1'b0;
        trg_r[a] <= 1'b0; sp_r[a] <= 1'b1;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          RegFast: fast_r <= cfg_wdata[RateBits-1:0];
          RegSlow: slow_r <= cfg_wdata[RateBits-1:0];
          RegMax:  max_r  <= cfg_wdata[RateBits-1:0];
          default: boff_r <= cfg_wdata[CountBits-1:0];
        endcase
      end
      if (div_done) begin
        if (cmd.div_sel == 2'd0) pfast_r <= per;
        else pslow_r <= per;
      end
      if (cmd.tick || cmd.start_cmd) begin
        act_r <= act; out_step_r <= stp; out_run_r <= run;
        for (int a = 0; a < NumAxes; a++) begin
          mode_r[a] <= m[a]; ph_r[a] <= p[a]; pm1_r[a] <= pm[a]; pc_r[a] <= pc[a];
          sl_r[a] <= sl[a]; unl_r[a] <= u[a]; dir_r[a] <= d[a]; trg_r[a] <= t[a];
          sp_r[a] <= s[a];
        end
      end
    end
  end

  assign result = {(ph_r[0] == PhDone) && (ph_r[1] == PhDone) && (ph_r[2] == PhDone),
                   ph_r[2], ph_r[1], ph_r[0], out_run_r,
                   dir_r[2], dir_r[1], dir_r[0], out_step_r};
endmodule

// ===== rtl/core/tahsg_ctrl.sv =====
// Module: controller sequencing period updates, tick commit and result handoff.
`timescale 1ns / 1ps
module tahsg_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_start,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic cfg_we,
  output tahsg_pkg::dp_cmd_t cmd,
  input  tahsg_pkg::dp_sts_t sts
);
  import tahsg_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_DIVF = 4'b0010, S_DIVS = 4'b0100, S_OUT = 4'b1000
  } state_t;
  state_t st_r, st_nxt;
  logic dirty_r, dirty_nxt, sub_r, sub_nxt;

  always_comb begin
    st_nxt = st_r; dirty_nxt = dirty_r | cfg_we; sub_nxt = sub_r;
    cmd = '0;
    in_ready = (st_r == S_IDLE) && !dirty_r && !cfg_we;
    out_valid = (st_r == S_OUT);
    case (st_r)
      S_IDLE: begin
        if (dirty_r && !cfg_we) begin
          cmd.div_go = 1'b1; cmd.div_sel = 2'd0; st_nxt = S_DIVF; sub_nxt = 1'b0;
          dirty_nxt = 1'b0;
        end else if (in_valid && in_ready) begin
          cmd.tick = !in_start; cmd.start_cmd = in_start; st_nxt = S_OUT;
        end
      end
      S_DIVF: begin
        cmd.div_sel = 2'd0;
        if (sts.div_done) begin
          st_nxt = S_DIVS; sub_nxt = 1'b1;
        end
      end
      S_DIVS: begin
        cmd.div_sel = 2'd1;
        if (sub_r) begin
          cmd.div_go = 1'b1; sub_nxt = 1'b0;
        end else if (sts.div_done) begin
          st_nxt = S_IDLE;
        end
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; dirty_r <= 1'b0; sub_r <= 1'b0;
    end else begin
      st_r <= st_nxt; dirty_r <= dirty_nxt; sub_r <= sub_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("accept while result pending");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick |-> !cmd.div_go) else $error("tick during division");
endmodule

// ===== rtl/core/three_axis_homing_step_generator.sv =====
// Top level: three-axis stepper homing sequencer with step generators.
// Usage:
//  - in channel: one request per 1 us timer tick (req_type 0) with the
//    switch levels, or a start request (req_type 1) that restarts homing.
//  - out channel: one result per request with step, direction, running,
//    phase and done flags.
//  - cfg port: APB writes to four rate/step registers at 4*i.
// Handshake: a request is taken while the controller is idle and its
// result shows the next cycle.
// After a register write, the fast and slow periods are recomputed by a
// bit-serial divider before the next request is accepted.
// Reset: synchronous, active low; registers return to their defaults and
// every axis stands idle in the check phase with matching periods.
// Stall: a result waits in its register while out_ready is low; no new
// request is taken until it leaves.
`timescale 1ns / 1ps
module three_axis_homing_step_generator (
  input  logic clk,
  input  logic rst_n,
  tahsg_if.sink   in_ch,
  tahsg_if.source out_ch,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [3:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import tahsg_pkg::*;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic cfg_we;
  logic [18:0] res;

  assign cfg_pready = 1'b1;
  // write lands on the access phase
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite;

  tahsg_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_start(in_ch.data[0]),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cfg_we, .cmd, .sts
  );
  tahsg_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_idx(cfg_paddr[3:2]),
    .cfg_wdata(cfg_pwdata), .cfg_rdata(cfg_prdata),
    .sensors(in_ch.data[3:1]), .result(res)
  );
  assign out_ch.data = res;
endmodule
